FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the number token normalizer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTN_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("NTN assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NTN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("NTN assertion failed");

`endif

FILE: src/ntn_pkg.sv
// ---------------------------------------------------------------------------
// ntn_pkg
// Types and character constants shared by the number token normalizer.
// ---------------------------------------------------------------------------
package ntn_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  // One queue entry: the one or two results caused by one request.
  // When verdict is set, the final result of the entry is the verdict.
  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic       two;
    logic       verdict;
    logic       is_num;
  } ntn_bundle_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } ntn_qstat_t;

endpackage

FILE: src/ntn_stream_ifs.sv
// ---------------------------------------------------------------------------
// ntn stream interfaces
// Valid/ready channels for character requests and normalized results.
// ---------------------------------------------------------------------------
interface ntn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_mark;

  modport source (output valid, output ch, output end_mark, input ready);
  modport sink   (input valid, input ch, input end_mark, output ready);
endinterface

interface ntn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_ch;
  logic       char_valid;
  logic       verdict_valid;
  logic       is_number;
  logic       last;

  modport source (output valid, output out_ch, output char_valid, output verdict_valid,
                  output is_number, output last, input ready);
  modport sink   (input valid, input out_ch, input char_valid, input verdict_valid,
                  input is_number, input last, output ready);
endinterface

FILE: src/ntn_front.sv
// ---------------------------------------------------------------------------
// ntn_front
// Accepts character requests, runs the number grammar and queues results.
// ---------------------------------------------------------------------------
module ntn_front import ntn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ntn_in_if.sink      in_i,
  input  ntn_qstat_t  qstat_i,
  output logic        push_o,
  output ntn_bundle_t bundle_o
);

  typedef enum logic [6:0] {
    PH_START   = 7'b0000001,
    PH_SIGNED  = 7'b0000010,
    PH_INT     = 7'b0000100,
    PH_FRAC    = 7'b0001000,
    PH_EXPMARK = 7'b0010000,
    PH_EXPSIGN = 7'b0100000,
    PH_EXPDIG  = 7'b1000000
  } ntn_phase_e;

  ntn_phase_e phase_q, phase_d;
  logic       nz_q, nz_d;
  logic       mant_q, mant_d;
  logic       pp_q, pp_d;
  logic       rej_q, rej_d;

  logic        accept;
  logic        emit;
  logic        is_dig, is_emark, is_sgn, ok;
  ntn_bundle_t bnd;

  assign in_i.ready = !qstat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  assign is_dig   = (in_i.ch >= CH_ZERO) && (in_i.ch <= CH_NINE);
  assign is_emark = (in_i.ch == CH_E_LO) || (in_i.ch == CH_E_UP);
  assign is_sgn   = (in_i.ch == CH_PLUS) || (in_i.ch == CH_MINUS);

  // The string ends well formed only after an integer digit, a fraction
  // with some mantissa digit, or an exponent digit.
  assign ok = !rej_q && ((phase_q == PH_INT) || ((phase_q == PH_FRAC) && mant_q) ||
                         (phase_q == PH_EXPDIG));

  always_comb begin
    phase_d = phase_q;
    nz_d    = nz_q;
    mant_d  = mant_q;
    pp_d    = pp_q;
    rej_d   = rej_q;
    emit    = 1'b0;
    bnd     = '0;
    if (in_i.end_mark) begin
      emit        = 1'b1;
      bnd.verdict = 1'b1;
      bnd.is_num  = ok;
      if (ok && (phase_q == PH_INT) && !nz_q) begin
        bnd.two = 1'b1;
        bnd.ch0 = CH_ZERO;
      end
      phase_d = PH_START;
      nz_d    = 1'b0;
      mant_d  = 1'b0;
      pp_d    = 1'b0;
      rej_d   = 1'b0;
    end else if (!rej_q) begin
      case (phase_q)
        PH_START, PH_SIGNED, PH_INT: begin
          if ((phase_q == PH_START) && is_sgn) begin
            emit    = (in_i.ch == CH_MINUS);
            bnd.ch0 = in_i.ch;
            phase_d = PH_SIGNED;
          end else if (is_dig) begin
            mant_d = 1'b1;
            if ((in_i.ch != CH_ZERO) || nz_q) begin
              emit    = 1'b1;
              bnd.ch0 = in_i.ch;
              nz_d    = 1'b1;
            end
            phase_d = PH_INT;
          end else if (in_i.ch == CH_POINT) begin
            emit    = !nz_q;
            bnd.ch0 = CH_ZERO;
            pp_d    = 1'b1;
            phase_d = PH_FRAC;
          end else if (is_emark && (phase_q == PH_INT)) begin
            emit = 1'b1;
            if (!nz_q) begin
              bnd.ch0 = CH_ZERO;
              bnd.ch1 = in_i.ch;
              bnd.two = 1'b1;
            end else begin
              bnd.ch0 = in_i.ch;
            end
            phase_d = PH_EXPMARK;
          end else begin
            rej_d = 1'b1;
          end
        end
        PH_FRAC: begin
          if (is_dig) begin
            emit = 1'b1;
            if (pp_q) begin
              bnd.ch0 = CH_POINT;
              bnd.ch1 = in_i.ch;
              bnd.two = 1'b1;
            end else begin
              bnd.ch0 = in_i.ch;
            end
            pp_d   = 1'b0;
            mant_d = 1'b1;
          end else if (is_emark && mant_q) begin
            emit    = 1'b1;
            bnd.ch0 = in_i.ch;
            pp_d    = 1'b0;
            phase_d = PH_EXPMARK;
          end else begin
            rej_d = 1'b1;
          end
        end
        PH_EXPMARK: begin
          if (is_sgn || is_dig) begin
            emit    = 1'b1;
            bnd.ch0 = in_i.ch;
            phase_d = is_sgn ? PH_EXPSIGN : PH_EXPDIG;
          end else begin
            rej_d = 1'b1;
          end
        end
        PH_EXPSIGN, PH_EXPDIG: begin
          if (is_dig) begin
            emit    = 1'b1;
            bnd.ch0 = in_i.ch;
            phase_d = PH_EXPDIG;
          end else begin
            rej_d = 1'b1;
          end
        end
        default: begin
          rej_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      nz_q    <= 1'b0;
      mant_q  <= 1'b0;
      pp_q    <= 1'b0;
      rej_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      nz_q    <= nz_d;
      mant_q  <= mant_d;
      pp_q    <= pp_d;
      rej_q   <= rej_d;
    end
  end

  assign push_o   = accept && emit;
  assign bundle_o = bnd;

endmodule

FILE: src/ntn_queue.sv
// ---------------------------------------------------------------------------
// ntn_queue
// Small register FIFO of result bundles between the front and the back.
// ---------------------------------------------------------------------------
module ntn_queue import ntn_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ntn_bundle_t push_data_i,
  input  logic        pop_i,
  output ntn_bundle_t head_o,
  output ntn_qstat_t  qstat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ntn_bundle_t      mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CW'(DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/ntn_back.sv
// ---------------------------------------------------------------------------
// ntn_back
// Splits queued bundles into single results behind an output register.
// ---------------------------------------------------------------------------
module ntn_back import ntn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ntn_bundle_t head_i,
  input  ntn_qstat_t  qstat_i,
  output logic        pop_o,
  output logic        busy_second_o,
  ntn_out_if.source   out_o
);

  logic       valid_q;
  logic       sel_q, sel_d;
  logic       load;
  logic       fin;
  logic [7:0] ch_d, ch_q;
  logic       cv_d, cv_q;
  logic       vv_d, vv_q;
  logic       num_d, num_q;
  logic       last_d, last_q;

  assign load = !qstat_i.empty && (!valid_q || out_o.ready);
  // The result being loaded is the last of its bundle.
  assign fin  = sel_q || !head_i.two;

  always_comb begin
    sel_d  = sel_q;
    last_d = fin;
    if (fin && head_i.verdict) begin
      ch_d  = '0;
      cv_d  = 1'b0;
      vv_d  = 1'b1;
      num_d = head_i.is_num;
    end else begin
      ch_d  = sel_q ? head_i.ch1 : head_i.ch0;
      cv_d  = 1'b1;
      vv_d  = 1'b0;
      num_d = 1'b0;
    end
    if (load) begin
      sel_d = !fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q   <= ch_d;
      cv_q   <= cv_d;
      vv_q   <= vv_d;
      num_q  <= num_d;
      last_q <= last_d;
    end
  end

  assign pop_o             = load && fin;
  assign busy_second_o     = sel_q;
  assign out_o.valid         = valid_q;
  assign out_o.out_ch        = ch_q;
  assign out_o.char_valid    = cv_q;
  assign out_o.verdict_valid = vv_q;
  assign out_o.is_number     = num_q;
  assign out_o.last          = last_q;

endmodule

FILE: src/number_token_normalizer.sv
// ---------------------------------------------------------------------------
// number_token_normalizer
// Checks a decimal number string and emits its JSON-normalized form.
// ---------------------------------------------------------------------------
// Each request on in_i carries one character of a number string, or an end
// mark. The block checks the string against the plain decimal float form
// (optional sign, digits with optional point and fraction or a point and
// digits, optional exponent with optional sign and digits) and on out_o emits
// a normalized copy as it goes: a plus sign is dropped, leading integer
// zeros are stripped, a lone 0 is supplied for a missing or all-zero integer
// part, a trailing point is dropped and the exponent is copied as it is.
// Characters are emitted before the string is known to be good; the end
// request yields a final result with verdict_valid set whose is_number says
// whether the emitted characters should be kept. The flag last marks the
// final result caused by each request; a character request may cause none.
// Rate: the front takes one request per cycle as long as the queue of DEPTH
// entries has room. The back delivers one result per cycle while out_o is
// ready, so a request that causes two results (a supplied 0 or point ahead
// of a character, or a 0 ahead of the verdict) holds the back for both; the
// queue absorbs such bursts. A request's first result enters the queue when
// the request is taken and then moves on into the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module number_token_normalizer import ntn_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ntn_in_if.sink     in_i,
  ntn_out_if.source  out_o
);

  // Front to queue: a bundle of results is pushed only when the request
  // actually causes at least one result.
  logic        push;
  ntn_bundle_t push_data;

  // Queue to back: head bundle and fill status.
  ntn_bundle_t head;
  ntn_qstat_t  qstat;
  logic        pop;
  logic        busy_second;

  ntn_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .qstat_i  (qstat),
    .push_o   (push),
    .bundle_o (push_data)
  );

  ntn_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  ntn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .busy_second_o (busy_second),
    .out_o         (out_o)
  );

  // A verdict is always the final result of its request.
  `NTN_ASSERT_SAME(a_verdict_last, clk_i, rst_ni, out_o.valid && out_o.verdict_valid, out_o.last)

  // A result is either a character or a verdict, never both.
  `NTN_ASSERT_SAME(a_kind_excl, clk_i, rst_ni, out_o.valid, !(out_o.char_valid && out_o.verdict_valid))

  // While the back is between the two halves of a bundle, the queue holds it.
  `NTN_ASSERT_SAME(a_second_held, clk_i, rst_ni, busy_second, !qstat.empty)

  // Popping a one-result bundle never leaves the back between two halves.
  `NTN_ASSERT_NEXT(a_first_no_pop, clk_i, rst_ni, pop && !busy_second, !busy_second)

endmodule
